// ===== design/circular_harmonic_encoder_core_assert.svh =====
// Assertion macros for the circular harmonic encoder core
`ifndef CIRCULAR_HARMONIC_ENCODER_CORE_ASSERT_SVH
`define CIRCULAR_HARMONIC_ENCODER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CHENC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("chenc assertion failed");

// next-cycle implication, checked out of reset
`define CHENC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("chenc assertion failed");

`endif

// ===== design/chenc_pkg.sv =====
// Types and constants shared by the circular harmonic encoder files
package chenc_pkg;

  localparam int SAMPLE_W = 24;
  localparam int CFG_W    = 18;
  localparam int INDEX_W  = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_COS_AZIMUTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_AZIMUTH = 1'd1;

  localparam logic signed [CFG_W-1:0] COS_RESET = 18'sd131071;
  localparam logic signed [CFG_W-1:0] SIN_RESET = 18'sd0;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] harmonic_value;
    logic [INDEX_W-1:0]         harmonic_index;
    logic                       is_last;
  } result_t;

  typedef enum logic [2:0] {
    SEQ_LOAD,
    SEQ_MUL_A,
    SEQ_MUL_B,
    SEQ_WRITE,
    SEQ_DONE
  } seq_state_t;

endpackage

// ===== design/chenc_stream_if.sv =====
// Valid/ready request channel carrying one payload
interface chenc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/circular_harmonic_encoder_core.sv =====
// Circular harmonic encoder: one sample in, 2*ORDER+1 harmonic samples out
`include "circular_harmonic_encoder_core_assert.svh"

// Each accepted sample produces 2*ORDER+1 results on out_ch, one per cycle while
// out_ch is ready, in index order: the sample itself, then sample*sin(kx) and
// sample*cos(kx) for k = 1..ORDER, the last one flagged by is_last. The single
// result channel sets the rate, and the next request is taken during the final
// harmonic of the current one. Each result passes through a four-register
// pipeline (issue, coefficient select, multiply, round and saturate), which
// out_ch back-pressure can stall. The sin/cos coefficients of all orders are
// built by a sequencer from cos_azimuth and sin_azimuth after reset and after
// every configuration write; it loads order 1, then steps through MUL_A, MUL_B
// and WRITE for each further order, and in_ch accepts no request until it is
// done.
module circular_harmonic_encoder_core #(
  parameter int ORDER = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  chenc_stream_if.sink                    in_ch,
  chenc_stream_if.source                  out_ch,
  input  logic                            cfg_we,
  input  logic [chenc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [chenc_pkg::CFG_W-1:0]     cfg_data
);
  import chenc_pkg::*;

  localparam int NCOEF = 2 * ORDER;
  localparam int HMAX  = 2 * ORDER;
  localparam int HW    = $clog2(HMAX + 1);
  localparam int TW    = $clog2(NCOEF);
  localparam int OW    = $clog2(ORDER + 1);
  localparam int COEF_W = 32;
  localparam int RPROD_W = COEF_W + CFG_W;
  localparam int OPROD_W = COEF_W + SAMPLE_W;
  localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sh4000_0000;

  function automatic logic signed [COEF_W-1:0] rsat32(input logic signed [RPROD_W:0] v);
    logic signed [RPROD_W:0] r;
    logic signed [RPROD_W-17:0] q;
    r = v + (RPROD_W+1)'(65536);
    q = r[RPROD_W:17];
    if (q > (RPROD_W-16)'(64'sd2147483647)) begin
      return 32'sh7fff_ffff;
    end else if (q < -(RPROD_W-16)'(64'sd2147483648)) begin
      return 32'sh8000_0000;
    end
    return q[COEF_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rsat24(input logic signed [OPROD_W-1:0] v);
    logic signed [OPROD_W-1:0] r;
    logic signed [OPROD_W-31:0] q;
    r = v + OPROD_W'(64'sd536870912);
    q = r[OPROD_W-1:30];
    if (q > (OPROD_W-30)'(64'sd8388607)) begin
      return 24'sh7f_ffff;
    end else if (q < -(OPROD_W-30)'(64'sd8388608)) begin
      return 24'sh80_0000;
    end
    return q[SAMPLE_W-1:0];
  endfunction

  // configuration registers
  logic signed [CFG_W-1:0] cos_az_r, sin_az_r;

  // coefficient sequencer
  seq_state_t seq_r, seq_nxt;
  logic [OW-1:0] ord_r;
  logic signed [COEF_W-1:0] c_r, s_r, nc_r;
  logic signed [RPROD_W-1:0] pa_r, pb_r;
  logic signed [COEF_W-1:0] coef_r [NCOEF];
  logic seq_load, seq_mul_a, seq_mul_b, seq_write, seq_ready;
  logic signed [COEF_W-1:0] ns_val;

  // pipeline
  logic iss_valid_r, s1_valid_r, s2_valid_r, out_valid_r;
  logic signed [SAMPLE_W-1:0] iss_sample_r, s1_sample_r;
  logic [HW-1:0] iss_h_r, s1_h_r, s2_h_r;
  logic signed [COEF_W-1:0] s1_coef_r;
  logic signed [OPROD_W-1:0] s2_prod_r;
  result_t out_data_r;
  logic rdy1, rdy2, rdy3, iss_adv, iss_last, accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_az_r <= COS_RESET;
      sin_az_r <= SIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COS_AZIMUTH: cos_az_r <= cfg_data;
        REG_SIN_AZIMUTH: sin_az_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    seq_nxt = seq_r;
    case (seq_r)
      SEQ_LOAD:  seq_nxt = (ORDER == 1) ? SEQ_DONE : SEQ_MUL_A;
      SEQ_MUL_A: seq_nxt = SEQ_MUL_B;
      SEQ_MUL_B: seq_nxt = SEQ_WRITE;
      SEQ_WRITE: seq_nxt = (ord_r == OW'(ORDER - 2)) ? SEQ_DONE : SEQ_MUL_A;
      SEQ_DONE:  seq_nxt = SEQ_DONE;
      default:   seq_nxt = SEQ_LOAD;
    endcase
    if (cfg_we) begin
      seq_nxt = SEQ_LOAD;
    end
  end

  always_comb begin
    seq_load  = 1'b0;
    seq_mul_a = 1'b0;
    seq_mul_b = 1'b0;
    seq_write = 1'b0;
    seq_ready = 1'b0;
    case (seq_r)
      SEQ_LOAD:  seq_load  = 1'b1;
      SEQ_MUL_A: seq_mul_a = 1'b1;
      SEQ_MUL_B: seq_mul_b = 1'b1;
      SEQ_WRITE: seq_write = 1'b1;
      SEQ_DONE:  seq_ready = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= SEQ_LOAD;
    end else begin
      seq_r <= seq_nxt;
    end
  end

  assign ns_val = rsat32({pa_r[RPROD_W-1], pa_r} + {pb_r[RPROD_W-1], pb_r});

  always_ff @(posedge clk) begin
    if (seq_load) begin
      c_r       <= {cos_az_r[CFG_W-1], cos_az_r, 13'b0};
      s_r       <= {sin_az_r[CFG_W-1], sin_az_r, 13'b0};
      coef_r[0] <= {sin_az_r[CFG_W-1], sin_az_r, 13'b0};
      coef_r[1] <= {cos_az_r[CFG_W-1], cos_az_r, 13'b0};
      ord_r     <= '0;
    end
    if (seq_mul_a) begin
      pa_r <= c_r * cos_az_r;
      pb_r <= s_r * sin_az_r;
    end
    if (seq_mul_b) begin
      nc_r <= rsat32({pa_r[RPROD_W-1], pa_r} - {pb_r[RPROD_W-1], pb_r});
      pa_r <= c_r * sin_az_r;
      pb_r <= s_r * cos_az_r;
    end
    if (seq_write) begin
      c_r <= nc_r;
      s_r <= ns_val;
      coef_r[TW'({ord_r + OW'(1), 1'b0})]       <= ns_val;
      coef_r[TW'({ord_r + OW'(1), 1'b0}) + 1'b1] <= nc_r;
      ord_r <= ord_r + OW'(1);
    end
  end

  assign rdy3     = !out_valid_r || out_ch.ready;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign iss_adv  = iss_valid_r && rdy1;
  assign iss_last = (iss_h_r == HW'(HMAX));
  assign in_ch.ready = seq_ready && (!iss_valid_r || (iss_last && rdy1));
  assign accept   = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_valid_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        iss_valid_r <= 1'b1;
      end else if (iss_adv && iss_last) begin
        iss_valid_r <= 1'b0;
      end
      if (rdy1) begin
        s1_valid_r <= iss_valid_r;
      end
      if (rdy2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (rdy3) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      iss_sample_r <= in_ch.data.sample_in;
      iss_h_r      <= '0;
    end else if (iss_adv) begin
      iss_h_r <= iss_h_r + HW'(1);
    end
    if (rdy1) begin
      s1_sample_r <= iss_sample_r;
      s1_h_r      <= iss_h_r;
      s1_coef_r   <= (iss_h_r == '0) ? COEF_ONE : coef_r[TW'(iss_h_r - HW'(1))];
    end
    if (rdy2) begin
      s2_prod_r <= s1_sample_r * s1_coef_r;
      s2_h_r    <= s1_h_r;
    end
    if (rdy3) begin
      out_data_r.harmonic_value <= rsat24(s2_prod_r);
      out_data_r.harmonic_index <= INDEX_W'(s2_h_r);
      out_data_r.is_last        <= (s2_h_r == HW'(HMAX));
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  `CHENC_ASSERT_NXT(a_cfg_blocks_input, clk, rst_n, cfg_we, !in_ch.ready)
  `CHENC_ASSERT_IMP(a_issue_in_range, clk, rst_n, iss_valid_r, iss_h_r <= HW'(HMAX))
  `CHENC_ASSERT_NXT(a_accept_starts_omni, clk, rst_n, accept, iss_valid_r && iss_h_r == '0)
  `CHENC_ASSERT_IMP(a_last_index, clk, rst_n, out_ch.valid && out_ch.data.is_last,
                    out_ch.data.harmonic_index == INDEX_W'(HMAX))

endmodule
